### sv/assert_macros.svh
// Assertion macros used by the spectrum row controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SRDB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence
`define SRDB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### sv/srdb_pkg.sv
// Shared constants, tables and functions of the spectrum row block
package srdb_pkg;

  localparam int FFT_POINTS_DEF = 256;
  localparam int PIX_W = 8;
  localparam int SMP_W = 8;
  localparam int TW_W = 32;
  localparam int THR_W = 34;
  localparam int THR_N = 256;
  localparam int FRAC_BITS = 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam real DB_STEP = 1.0 / 50.0;

  typedef logic [THR_W-1:0] thresh_tab_t [THR_N];

  // Unsigned long division by shift and subtract, for table construction only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q30 sine and cosine by truncating series, packed as {sin, cos}
  function automatic logic [2*TW_W-1:0] series_q30(input longint unsigned x);
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cc;
    longint unsigned k;
    ts = x;
    tc = 64'd1 << FRAC_BITS;
    ss = longint'(x);
    cc = longint'(64'd1 << FRAC_BITS);
    for (k = 1; k <= 9; k++) begin
      ts = udiv64(((((ts * x) >> FRAC_BITS) * x) >> FRAC_BITS),
                  (2 * k) * (2 * k + 1));
      tc = udiv64(((((tc * x) >> FRAC_BITS) * x) >> FRAC_BITS),
                  (2 * k - 1) * (2 * k));
      if (k[0]) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
    end
    return {ss[TW_W-1:0], cc[TW_W-1:0]};
  endfunction

  // Smallest power reaching each pixel level: ceil(65536 * 10^(p/50))
  function automatic thresh_tab_t build_thresh();
    thresh_tab_t tab;
    real r;
    real frac;
    longint t;
    tab[0] = '0;
    for (int p = 1; p < THR_N; p++) begin
      r = 65536.0 * (10.0 ** (real'(p) * DB_STEP));
      t = longint'(r);
      if (real'(t) > r) begin
        t = t - 1;
      end
      frac = r - real'(t);
      if (frac > 1.0e-5) begin
        t = t + 1;
      end
      tab[p] = t[THR_W-1:0];
    end
    return tab;
  endfunction

  localparam thresh_tab_t THRESH = build_thresh();

  typedef struct packed {
    logic smp_we;
    logic mac_issue;
    logic mac_first;
    logic srch_step;
    logic srch_first;
    logic [2:0] srch_bit;
    logic pix_we;
    logic pix_re;
  } dp_cmd_t;

endpackage

### sv/srdb_ram.sv
// Generic simple dual-port RAM with registered read
module srdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/srdb_datapath.sv
// Datapath: sample and pixel stores, twiddle ROM, DFT MAC, power and dB search
module srdb_datapath
  import srdb_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic                          clk,
  input  dp_cmd_t                       cmd,
  input  logic [$clog2(FFT_POINTS)-1:0] smp_waddr,
  input  logic [$clog2(FFT_POINTS)-1:0] smp_raddr,
  input  logic [$clog2(FFT_POINTS)-1:0] tw_idx,
  input  logic [$clog2(FFT_POINTS)-1:0] pix_waddr,
  input  logic [$clog2(FFT_POINTS)-1:0] pix_raddr,
  input  logic [$clog2(FFT_POINTS)-1:0] pos,
  input  logic [2*SMP_W-1:0]            in_data,
  output logic [2*PIX_W:0]              out_data
);

  localparam int ADDR_W = $clog2(FFT_POINTS);
  localparam int PROD_W = SMP_W + 1 + TW_W;
  localparam int ACC_W = PROD_W + 1 + ADDR_W;
  localparam int MAG_W = ACC_W - FRAC_BITS + 1;
  localparam int POW_W = 2 * MAG_W + 1;

  typedef logic [2*TW_W-1:0] tw_rom_t [FFT_POINTS];

  function automatic tw_rom_t build_tw();
    tw_rom_t rom;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    logic [2*TW_W-1:0] sc;
    logic signed [TW_W-1:0] s;
    logic signed [TW_W-1:0] c;
    for (int j = 0; j < FFT_POINTS; j++) begin
      q = 64'(4 * j) >> ADDR_W;
      r = 64'(4 * j) & 64'(FFT_POINTS - 1);
      x = (HALF_PI_Q30 * r) >> ADDR_W;
      sc = series_q30(x);
      s = sc[2*TW_W-1:TW_W];
      c = sc[TW_W-1:0];
      case (q[1:0])
        2'd0:    rom[j] = {c, s};
        2'd1:    rom[j] = {-s, c};
        2'd2:    rom[j] = {-c, -s};
        default: rom[j] = {s, -c};
      endcase
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  logic [2*SMP_W-1:0]        smp_rdata;
  logic [PIX_W-1:0]          pix_rdata;
  logic signed [TW_W-1:0]    tw_cos;
  logic signed [TW_W-1:0]    tw_sin;
  logic                      iss1;
  logic                      first1;
  logic                      odd1;
  logic                      iss2;
  logic                      first2;
  logic signed [SMP_W:0]     a_val;
  logic signed [SMP_W:0]     b_val;
  logic signed [PROD_W-1:0]  p_rc;
  logic signed [PROD_W-1:0]  p_bs;
  logic signed [PROD_W-1:0]  p_bc;
  logic signed [PROD_W-1:0]  p_as;
  logic signed [PROD_W:0]    sum_re;
  logic signed [PROD_W:0]    sum_im;
  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;
  logic [ACC_W-1:0]          mag_re;
  logic [ACC_W-1:0]          mag_im;
  logic [ACC_W:0]            rsum_re;
  logic [ACC_W:0]            rsum_im;
  logic [MAG_W-1:0]          rnd_re;
  logic [MAG_W-1:0]          rnd_im;
  logic [2*MAG_W-1:0]        sq_re;
  logic [2*MAG_W-1:0]        sq_im;
  logic [POW_W-1:0]          power;
  logic [PIX_W-1:0]          pix;
  logic [PIX_W-1:0]          base;
  logic [PIX_W-1:0]          cand;
  logic [PIX_W-1:0]          out_bin;
  logic                      out_last;

  srdb_ram #(.WIDTH(2*SMP_W), .DEPTH(FFT_POINTS)) u_smp_ram (
    .clk   (clk),
    .we    (cmd.smp_we),
    .waddr (smp_waddr),
    .wdata (in_data ^ {1'b1, {(SMP_W-1){1'b0}}, 1'b1, {(SMP_W-1){1'b0}}}),
    .re    (cmd.mac_issue),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  srdb_ram #(.WIDTH(PIX_W), .DEPTH(FFT_POINTS)) u_pix_ram (
    .clk   (clk),
    .we    (cmd.pix_we),
    .waddr (pix_waddr),
    .wdata (pix),
    .re    (cmd.pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  always_comb begin
    a_val = odd1 ? -$signed({1'b0, smp_rdata[SMP_W-1:0]})
                 : $signed({1'b0, smp_rdata[SMP_W-1:0]});
    b_val = odd1 ? -$signed({1'b0, smp_rdata[2*SMP_W-1:SMP_W]})
                 : $signed({1'b0, smp_rdata[2*SMP_W-1:SMP_W]});
    sum_re = (PROD_W+1)'(p_rc) + (PROD_W+1)'(p_bs);
    sum_im = (PROD_W+1)'(p_bc) - (PROD_W+1)'(p_as);
    mag_re = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
    mag_im = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
    rsum_re = {1'b0, mag_re} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
    rsum_im = {1'b0, mag_im} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
    base = cmd.srch_first ? '0 : pix;
    cand = base | (PIX_W'(1) << cmd.srch_bit);
  end

  always_ff @(posedge clk) begin
    tw_cos <= TW_ROM[tw_idx][2*TW_W-1:TW_W];
    tw_sin <= TW_ROM[tw_idx][TW_W-1:0];
    iss1 <= cmd.mac_issue;
    first1 <= cmd.mac_first;
    odd1 <= smp_raddr[0];
    iss2 <= iss1;
    first2 <= first1;
    p_rc <= a_val * tw_cos;
    p_bs <= b_val * tw_sin;
    p_bc <= b_val * tw_cos;
    p_as <= a_val * tw_sin;
    if (iss2) begin
      acc_re <= first2 ? ACC_W'(sum_re) : acc_re + ACC_W'(sum_re);
      acc_im <= first2 ? ACC_W'(sum_im) : acc_im + ACC_W'(sum_im);
    end
    rnd_re <= rsum_re[ACC_W:FRAC_BITS];
    rnd_im <= rsum_im[ACC_W:FRAC_BITS];
    sq_re <= rnd_re * rnd_re;
    sq_im <= rnd_im * rnd_im;
    power <= POW_W'(sq_re) + POW_W'(sq_im);
    if (cmd.srch_step) begin
      pix <= (POW_W'(THRESH[cand]) <= power) ? cand : base;
    end
    if (cmd.pix_re) begin
      out_bin <= PIX_W'(pos);
      out_last <= (pos == ADDR_W'(FFT_POINTS - 1));
    end
  end

  assign out_data = {out_last, out_bin, pix_rdata};

endmodule

### sv/srdb_ctrl.sv
// Controller: input sequencing, transform loop counters and output valid
module srdb_ctrl
  import srdb_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output dp_cmd_t                       cmd,
  output logic [$clog2(FFT_POINTS)-1:0] pos,
  output logic [$clog2(FFT_POINTS)-1:0] n,
  output logic [$clog2(FFT_POINTS)-1:0] idx,
  output logic [$clog2(FFT_POINTS)-1:0] k,
  output logic [$clog2(FFT_POINTS)-1:0] pix_raddr
);

  `include "assert_macros.svh"

  localparam int ADDR_W = $clog2(FFT_POINTS);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(FFT_POINTS - 1);
  localparam logic [ADDR_W-1:0] DC = ADDR_W'(FFT_POINTS / 2);
  localparam logic [2:0] DRAIN_LAST = 3'd4;

  typedef enum logic [2:0] {COLLECT, MAC, DRAIN, SEARCH, STORE} state_t;

  state_t     state;
  logic       row_ready;
  logic       pend;
  logic [2:0] cnt;
  logic [2:0] srch_bit;
  logic       accept;

  assign s_tready = (state == COLLECT) && !m_tvalid && !pend;
  assign accept = s_tvalid && s_tready;
  assign pix_raddr = (pos == DC) ? DC - ADDR_W'(1) : pos;

  always_comb begin
    cmd = '0;
    cmd.smp_we = accept;
    cmd.pix_re = accept && row_ready;
    cmd.mac_issue = (state == MAC);
    cmd.mac_first = (state == MAC) && (n == '0);
    cmd.srch_step = (state == SEARCH);
    cmd.srch_first = (srch_bit == 3'd7);
    cmd.srch_bit = srch_bit;
    cmd.pix_we = (state == STORE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= COLLECT;
      row_ready <= 1'b0;
      pend <= 1'b0;
      m_tvalid <= 1'b0;
      pos <= '0;
      n <= '0;
      idx <= '0;
      k <= '0;
      cnt <= '0;
      srch_bit <= 3'd7;
    end else begin
      if (pend) begin
        pend <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        COLLECT: begin
          if (accept) begin
            pend <= row_ready;
            pos <= pos + ADDR_W'(1);
            if (pos == LAST) begin
              state <= MAC;
              n <= '0;
              idx <= '0;
              k <= '0;
            end
          end
        end
        MAC: begin
          n <= n + ADDR_W'(1);
          idx <= idx + k;
          if (n == LAST) begin
            state <= DRAIN;
            cnt <= '0;
          end
        end
        DRAIN: begin
          cnt <= cnt + 3'd1;
          if (cnt == DRAIN_LAST) begin
            state <= SEARCH;
            srch_bit <= 3'd7;
          end
        end
        SEARCH: begin
          srch_bit <= srch_bit - 3'd1;
          if (srch_bit == 3'd0) begin
            state <= STORE;
          end
        end
        STORE: begin
          srch_bit <= 3'd7;
          n <= '0;
          idx <= '0;
          if (k == LAST) begin
            row_ready <= 1'b1;
            state <= COLLECT;
          end else begin
            k <= k + ADDR_W'(1);
            state <= MAC;
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

  `SRDB_ASSERT_NEXT(a_pend_to_valid, pend, m_tvalid, "pixel read did not raise valid")
  `SRDB_ASSERT_NEXT(a_block_end, accept && pos == LAST, state == MAC && pos == '0,
    "block end did not start the transform")
  `SRDB_ASSERT_NEXT(a_row_done, state == STORE && k == LAST, row_ready && state == COLLECT,
    "last bin did not publish the row")
  `SRDB_ASSERT(a_no_result_first, !row_ready |-> !cmd.pix_re, "result before first row")

endmodule

### sv/spectrum_row_db_pixels_top.sv
// Top level of the spectrum row to dB pixel block
// Usage:
//   Input stream s_*: one raw I/Q byte pair per transfer. Every FFT_POINTS
//   transfers form a block; after the block's last transfer the block runs a
//   direct DFT with one complex multiply-accumulate per cycle, during which
//   s_tready is low.
//   Output stream m_*: one pixel of the previous block per accepted input,
//   starting with the second block; m_tlast marks the last bin of a row.
//   Output timing: an accepted input reads its pixel into the RAM's output
//   register and sets a pending flag; the pending flag then raises m_tvalid.
//   Input pacing while collecting: once rows are output, a new input waits
//   until the pending read and the single output register have cleared.
//   Stall: while m_tvalid is held by a low m_tready, no input is accepted;
//   the transform itself keeps running.
//   Reset: rst clears the position count and the row flag; no pixels are
//   emitted until a full block has been collected after reset.
//   FFT_POINTS must be a power of two.
module spectrum_row_db_pixels_top
  import srdb_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample_i [7:0], sample_q [15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pixel [7:0], bin_index [15:8]
  output logic        m_tlast
);

  localparam int ADDR_W = $clog2(FFT_POINTS);

  dp_cmd_t           cmd;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] pix_raddr;
  logic [2*PIX_W:0]  out_data;

  srdb_ctrl #(.FFT_POINTS(FFT_POINTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .pos       (pos),
    .n         (n),
    .idx       (idx),
    .k         (k),
    .pix_raddr (pix_raddr)
  );

  srdb_datapath #(.FFT_POINTS(FFT_POINTS)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .smp_waddr (pos),
    .smp_raddr (n),
    .tw_idx    (idx),
    .pix_waddr (k),
    .pix_raddr (pix_raddr),
    .pos       (pos),
    .in_data   (s_tdata),
    .out_data  (out_data)
  );

  assign m_tdata = out_data[2*PIX_W-1:0];
  assign m_tlast = out_data[2*PIX_W];

endmodule

### tb/testbench.sv
// Testbench for spectrum_row_db_pixels_top: random and directed I/Q blocks against a DFT/dB predictor
`timescale 1ns / 100ps

module testbench;
  import srdb_pkg::*;

  localparam int NPTS = 256;
  localparam int NBLOCKS = 5;
  localparam int NEXTRA = 20;
  localparam int TOTAL = NBLOCKS * NPTS + NEXTRA;
  localparam int HOLD_AT = 520;
  localparam int HOLD_CYCLES = 400;
  localparam int PAUSE_AT = 700;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] bin;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  spectrum_row_db_pixels_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  logic [15:0]     sample_pending_q[$];
  pixel_t          pixel_expect_q[$];
  int              errors = 0;
  int              in_count = 0;
  logic            in_took = 0;
  logic            rx_hold = 0;
  logic            hold_done = 0;
  int              hold_cnt = 0;

  longint          tw_cos[NPTS];
  longint          tw_sin[NPTS];
  longint unsigned level_floor[256];
  logic [15:0]     block_samples[NPTS];
  logic [7:0]      row_pixels[NPTS];
  int              block_pos = 0;
  bit              row_valid = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint q30_round(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 29)) >>> 30;
    return -((-v + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic bit power_reaches(longint unsigned v, logic [1903:0] tenp);
    logic [1903:0] pw;
    pw = 1;
    repeat (50) pw = pw * v;
    return pw >= (tenp << 800);
  endfunction

  task automatic build_predictor_tables();
    longint unsigned x, ts, tc, t;
    longint ss, cc;
    int q, r;
    logic [1903:0] tenp;
    for (int j = 0; j < NPTS; j++) begin
      q = (4 * j) / NPTS;
      r = (4 * j) % NPTS;
      x = 64'd1686629713 * r / NPTS;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cc = longint'(64'd1 << 30);
      for (longint unsigned k = 1; k <= 9; k++) begin
        ts = ((((ts * x) >> 30) * x) >> 30) / ((2 * k) * (2 * k + 1));
        tc = ((((tc * x) >> 30) * x) >> 30) / ((2 * k - 1) * (2 * k));
        if (k[0]) begin
          ss -= longint'(ts);
          cc -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cc += longint'(tc);
        end
      end
      case (q)
        0: begin tw_cos[j] = cc; tw_sin[j] = ss; end
        1: begin tw_cos[j] = -ss; tw_sin[j] = cc; end
        2: begin tw_cos[j] = -cc; tw_sin[j] = -ss; end
        default: begin tw_cos[j] = ss; tw_sin[j] = -cc; end
      endcase
    end
    level_floor[0] = 0;
    tenp = 1;
    for (int p = 1; p < 256; p++) begin
      tenp = tenp * 10;
      t = longint'(65536.0 * (10.0 ** (real'(p) / 50.0)));
      while (!power_reaches(t, tenp)) t++;
      while (t > 1 && power_reaches(t - 1, tenp)) t--;
      level_floor[p] = t;
    end
  endtask

  task automatic form_pixel_row();
    longint re, im, a, b, xr, xi;
    longint unsigned pw;
    int idx, pix;
    for (int k = 0; k < NPTS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < NPTS; n++) begin
        idx = (k * n) % NPTS;
        a = longint'(block_samples[n][7:0]);
        b = longint'(block_samples[n][15:8]);
        if (n % 2 == 1) begin
          a = -a;
          b = -b;
        end
        re += a * tw_cos[idx] + b * tw_sin[idx];
        im += b * tw_cos[idx] - a * tw_sin[idx];
      end
      xr = q30_round(re);
      xi = q30_round(im);
      pw = longint'(xr * xr) + longint'(xi * xi);
      pix = 0;
      for (int p = 1; p < 256; p++) begin
        if (pw >= level_floor[p]) pix = p;
        else break;
      end
      row_pixels[k] = pix[7:0];
    end
    row_pixels[NPTS / 2] = row_pixels[NPTS / 2 - 1];
  endtask

  task automatic predict_sample(logic [15:0] smp);
    pixel_t e;
    if (row_valid) begin
      e.pixel = row_pixels[block_pos];
      e.bin = block_pos[7:0];
      e.last = (block_pos == NPTS - 1);
      pixel_expect_q.push_back(e);
    end
    block_samples[block_pos] = smp ^ 16'h8080;
    block_pos++;
    if (block_pos == NPTS) begin
      form_pixel_row();
      row_valid = 1;
      block_pos = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int send_idle_pct();
    if (in_count < 430) return 23;
    if (in_count < 860) return 64;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (in_count < 430) return 64;
    if (in_count < 860) return 23;
    return 0;
  endfunction

  // accept inputs and check outputs
  always @(posedge clk) begin
    pixel_t e;
    in_took <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_sample(s_tdata);
        in_count <= in_count + 1;
      end
      if (m_tvalid && m_tready) begin
        if (pixel_expect_q.size() == 0) begin
          report_mismatch("unexpected pixel at bin", m_tdata[15:8], -1);
        end else begin
          e = pixel_expect_q.pop_front();
          if (m_tdata[7:0] !== e.pixel) report_mismatch("pixel", m_tdata[7:0], e.pixel);
          if (m_tdata[15:8] !== e.bin) report_mismatch("bin_index", m_tdata[15:8], e.bin);
          if (m_tlast !== e.last) report_mismatch("last_in_row", m_tlast, e.last);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!rst) begin
      if (!rx_hold && !hold_done && in_count == HOLD_AT) begin
        rx_hold <= 1;
        hold_cnt <= 0;
      end else if (rx_hold) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES) begin
          rx_hold <= 0;
          hold_done <= 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_took) begin
        // hold until the transfer completes
      end else if (sample_pending_q.size() == 0
                   || (in_count == PAUSE_AT && pixel_expect_q.size() != 0)
                   || $urandom_range(99) < send_idle_pct()) begin
        s_tvalid <= 0;
      end else begin
        s_tdata <= sample_pending_q.pop_front();
        s_tvalid <= 1;
      end
      m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= recv_idle_pct());
    end
  end

  initial begin
    logic [7:0] edge_vals[8];
    logic [7:0] si, sq;
    edge_vals = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h81, 8'h55};
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    m_tready = 0;
    build_predictor_tables();
    for (int blk = 0; blk < NBLOCKS; blk++) begin
      for (int n = 0; n < NPTS; n++) begin
        case (blk)
          0: begin
            si = (n < 25) ? edge_vals[n % 8] : 8'($urandom);
            sq = (n < 25) ? edge_vals[(n / 8 + n) % 8] : 8'($urandom);
          end
          1: begin si = 8'h80; sq = 8'h80; end
          2: begin si = 8'h7F; sq = 8'h7F; end
          3: begin
            si = 8'h80 + 8'($urandom_range(2)) - 8'd1;
            sq = 8'h80 + 8'($urandom_range(2)) - 8'd1;
          end
          default: begin si = 8'($urandom); sq = 8'($urandom); end
        endcase
        sample_pending_q.push_back({sq, si});
      end
    end
    repeat (NEXTRA) sample_pending_q.push_back(16'($urandom));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait (in_count == TOTAL);
    wait (pixel_expect_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### spectrum_row_db_pixels_top.f
+incdir+sv
sv/srdb_pkg.sv
sv/srdb_ram.sv
sv/srdb_datapath.sv
sv/srdb_ctrl.sv
sv/spectrum_row_db_pixels_top.sv
tb/testbench.sv
